/* rtl/gripper_table_clearance_clamp_macros.svh */
// Assertion macros shared by the clearance clamp RTL
`ifndef GRIPPER_TABLE_CLEARANCE_CLAMP_MACROS_SVH
`define GRIPPER_TABLE_CLEARANCE_CLAMP_MACROS_SVH

// Check on the next edge, active during reset as well
`define GTCC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("gtcc assertion failed");

// Same-edge implication, held off while reset is asserted
`define GTCC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gtcc assertion failed");

// Implication after a fixed number of cycles, held off while reset is asserted
`define GTCC_ASSERT_DELAY(lbl, ante, n, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##n (cons)) \
        else $error("gtcc assertion failed");

`endif

/* rtl/gtcc_pkg.sv */
// Shared widths, constants and types of the clearance clamp
`default_nettype none

package gtcc_pkg;

    localparam int PZ_W         = 23;
    localparam int ROT_W        = 19;
    localparam int THR_W        = 21;
    localparam int ADJ_W        = 23;
    localparam int LIFT_W       = 22;
    localparam int PXZ_W        = 22;
    localparam int U_W          = 26;
    localparam int H_W          = 34;
    localparam int SERIES_TERMS = 18;
    localparam int STEP_LAT     = 4;
    localparam int HORNER_LAT   = STEP_LAT * SERIES_TERMS;
    localparam int PIPE_LAT     = HORNER_LAT + 7;

    localparam logic signed [H_W-1:0] Q30_ONE      = 34'sd1073741824;
    localparam logic [16:0]           WIDTH_Q20    = 17'd104858;
    localparam logic [15:0]           THICK_Q20    = 16'd58196;
    localparam logic [LIFT_W-1:0]     LIFT_MAX     = 22'd4194303;
    localparam logic [THR_W-1:0]      THRESH_RESET = 21'd5243;

    typedef struct packed {
        logic signed [PZ_W-1:0]  pz;
        logic signed [ROT_W-1:0] rx;
        logic signed [ROT_W-1:0] ry;
        logic signed [PXZ_W-1:0] pxz;
        logic signed [PXZ_W-1:0] pyz;
    } t_side;

endpackage

`default_nettype wire

/* rtl/gtcc_horner.sv */
// Pipelined Horner series in u: four register stages per term
`default_nettype none

module gtcc_horner #(
    parameter int FIRST = 0
) (
    input  wire logic                            i_clk,
    input  wire logic [gtcc_pkg::U_W-1:0]        i_u,
    output logic signed [gtcc_pkg::H_W-1:0]      o_h
);

    localparam int N   = gtcc_pkg::SERIES_TERMS;
    localparam int UW  = gtcc_pkg::U_W;
    localparam int HW  = gtcc_pkg::H_W;
    localparam int MW  = UW + HW;
    localparam int PW  = MW + 1 - 20;
    localparam int SH  = PW;
    localparam int LOW = 20;
    localparam int RW  = SH - 2;
    localparam int PHW = PW - LOW + RW;
    localparam int PLW = LOW + RW;
    localparam int QW  = PW + RW - SH;
    localparam int EW  = 12;

    logic [UW-1:0]        w_u [N];
    logic signed [HW-1:0] w_h [N+1];

    assign w_u[0] = i_u;
    assign w_h[0] = gtcc_pkg::Q30_ONE;
    assign o_h    = w_h[N];

    genvar j;
    generate
        for (j = 0; j < N; j++) begin : g_term
            localparam int F = 2 * (N - j) + FIRST;
            localparam int C = F * (F + 1);
            localparam logic [10:0]   DIV  = 11'(C);
            localparam logic [RW-1:0] RCP  = RW'((64'd1 << SH) / 64'(C));
            localparam logic [MW:0]   HALF = (MW + 1)'(C) << 19;

            logic [MW-1:0]        r_m;
            logic                 r_neg1, r_neg2, r_neg3;
            logic [PW-1:0]        r_mp2, r_mp3;
            logic [PHW-1:0]       r_phi;
            logic [PLW-1:0]       r_plo;
            logic [QW-1:0]        r_q;
            logic signed [HW-1:0] r_h;
            logic [HW-1:0]        w_mag;
            logic [MW:0]          w_msum;
            logic [PW-1:0]        w_mp;
            logic [PW+RW-1:0]     w_prod;
            logic [QW-1:0]        n_q;
            logic [EW-1:0]        w_rem;
            logic [QW-1:0]        w_qf;
            logic [HW-1:0]        w_qt;
            logic signed [HW-1:0] n_h;

            always_comb begin
                w_mag  = w_h[j][HW-1] ? (~w_h[j] + 1'b1) : w_h[j];
                w_msum = {1'b0, r_m} + HALF;
                w_mp   = w_msum[MW:20];
                w_prod = {r_phi, {LOW{1'b0}}} + (PW + RW)'(r_plo);
                n_q    = w_prod[PW+RW-1:SH];
                w_rem  = EW'(r_mp3) - EW'(r_q * DIV);
                w_qf   = r_q + QW'(w_rem >= EW'(DIV));
                w_qt   = HW'(w_qf);
                n_h    = r_neg3 ? (gtcc_pkg::Q30_ONE + w_qt) : (gtcc_pkg::Q30_ONE - w_qt);
            end

            always_ff @(posedge i_clk) begin
                r_m    <= MW'(w_u[j]) * MW'(w_mag);
                r_neg1 <= w_h[j][HW-1];
                r_neg2 <= r_neg1;
                r_mp2  <= w_mp;
                r_phi  <= PHW'(w_mp[PW-1:LOW]) * PHW'(RCP);
                r_plo  <= PLW'(w_mp[LOW-1:0]) * PLW'(RCP);
                r_neg3 <= r_neg2;
                r_mp3  <= r_mp2;
                r_q    <= n_q;
                r_h    <= n_h;
            end

            assign w_h[j+1] = r_h;

            if (j < N - 1) begin : g_ucarry
                logic [UW-1:0] r_u1, r_u2, r_u3, r_u4;

                always_ff @(posedge i_clk) begin
                    r_u1 <= w_u[j];
                    r_u2 <= r_u1;
                    r_u3 <= r_u2;
                    r_u4 <= r_u3;
                end

                assign w_u[j+1] = r_u4;
            end
        end
    endgenerate

endmodule

`default_nettype wire

/* rtl/gripper_table_clearance_clamp.sv */
// Top level of the gripper table clearance clamp pipeline
`default_nettype none

// Takes one pose on every clock (start with busy low; busy never rises) and
// returns its result with o_valid high for one cycle once it leaves the
// pipeline. The receiver cannot stall, and none is needed: the datapath
// is a fixed pipeline whose length is set by the two sin(t)/t and
// (1-cos(t))/t^2 Horner series, 18 terms each at four stages per term
// (multiply, reciprocal multiply, quotient, correction), run side by side,
// plus three stages in front and four behind. The clearance threshold resets
// to 5 mm and is written through the cfg channel, which is always ready; write
// it only while no pose is in flight.

`include "gripper_table_clearance_clamp_macros.svh"

module gripper_table_clearance_clamp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [gtcc_pkg::PZ_W-1:0]    i_position_z,
    input  wire logic signed [gtcc_pkg::ROT_W-1:0]   i_rotation_x,
    input  wire logic signed [gtcc_pkg::ROT_W-1:0]   i_rotation_y,
    input  wire logic signed [gtcc_pkg::ROT_W-1:0]   i_rotation_z,
    output logic                                     o_valid,
    output logic signed [gtcc_pkg::ADJ_W-1:0]        o_adjusted_z,
    output logic [gtcc_pkg::LIFT_W-1:0]              o_lift_amount,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [gtcc_pkg::THR_W-1:0]          i_cfg_data
);

    localparam int PZW  = gtcc_pkg::PZ_W;
    localparam int RTW  = gtcc_pkg::ROT_W;
    localparam int PXW  = gtcc_pkg::PXZ_W;
    localparam int UW   = gtcc_pkg::U_W;
    localparam int HW   = gtcc_pkg::H_W;
    localparam int DL   = gtcc_pkg::HORNER_LAT;
    localparam int LAT  = gtcc_pkg::PIPE_LAT;

    function automatic logic signed [PXW-1:0] rnd_p16(input logic signed [37:0] x);
        logic [37:0] m;
        logic [37:0] q;
        m = x[37] ? (~x + 1'b1) : x;
        q = (m + 38'd32768) >> 16;
        return x[37] ? -PXW'(q) : PXW'(q);
    endfunction

    function automatic logic signed [40:0] rnd_b17(input logic signed [55:0] x);
        logic [55:0] m;
        logic [55:0] q;
        m = x[55] ? (~x + 1'b1) : x;
        q = (m + 56'd65536) >> 17;
        return x[55] ? -41'(q) : 41'(q);
    endfunction

    function automatic logic signed [40:0] rnd_a16(input logic signed [52:0] x);
        logic [52:0] m;
        logic [52:0] q;
        m = x[52] ? (~x + 1'b1) : x;
        q = (m + 53'd32768) >> 16;
        return x[52] ? -41'(q) : 41'(q);
    endfunction

    // configuration
    logic [gtcc_pkg::THR_W-1:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= gtcc_pkg::THRESH_RESET;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    // input register
    logic                   r_s0_vld;
    logic signed [PZW-1:0]  r_s0_pz;
    logic signed [RTW-1:0]  r_s0_rx, r_s0_ry, r_s0_rz;

    // squares and cross products
    logic                   r_s1_vld;
    logic signed [PZW-1:0]  r_s1_pz;
    logic signed [RTW-1:0]  r_s1_rx, r_s1_ry;
    logic [36:0]            r_s1_sqx, r_s1_sqy, r_s1_sqz;
    logic signed [37:0]     r_s1_pxz, r_s1_pyz;
    logic signed [37:0]     w_sqx, w_sqy, w_sqz;

    // angle term u and rounded cross products
    logic                   r_s2_vld;
    logic [UW-1:0]          r_s2_u;
    gtcc_pkg::t_side        r_s2_side;
    logic [37:0]            w_t2;
    logic [UW-1:0]          n_s2_u;

    always_comb begin
        w_sqx  = r_s0_rx * r_s0_rx;
        w_sqy  = r_s0_ry * r_s0_ry;
        w_sqz  = r_s0_rz * r_s0_rz;
        w_t2   = 38'(r_s1_sqx) + 38'(r_s1_sqy) + 38'(r_s1_sqz);
        n_s2_u = UW'((w_t2 + 38'd2048) >> 12);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s0_vld <= start && !busy;
            r_s1_vld <= r_s0_vld;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_pz <= i_position_z;
        r_s0_rx <= i_rotation_x;
        r_s0_ry <= i_rotation_y;
        r_s0_rz <= i_rotation_z;

        r_s1_pz  <= r_s0_pz;
        r_s1_rx  <= r_s0_rx;
        r_s1_ry  <= r_s0_ry;
        r_s1_sqx <= 37'(w_sqx);
        r_s1_sqy <= 37'(w_sqy);
        r_s1_sqz <= 37'(w_sqz);
        r_s1_pxz <= r_s0_rx * r_s0_rz;
        r_s1_pyz <= r_s0_ry * r_s0_rz;

        r_s2_u         <= n_s2_u;
        r_s2_side.pz   <= r_s1_pz;
        r_s2_side.rx   <= r_s1_rx;
        r_s2_side.ry   <= r_s1_ry;
        r_s2_side.pxz  <= rnd_p16(r_s1_pxz);
        r_s2_side.pyz  <= rnd_p16(r_s1_pyz);
    end

    // series
    logic signed [HW-1:0] w_a, w_b;

    gtcc_horner #(.FIRST(0)) u_hor_a (
        .i_clk (i_clk),
        .i_u   (r_s2_u),
        .o_h   (w_a)
    );

    gtcc_horner #(.FIRST(1)) u_hor_b (
        .i_clk (i_clk),
        .i_u   (r_s2_u),
        .o_h   (w_b)
    );

    // hold pose data alongside the series
    gtcc_pkg::t_side r_dl     [DL];
    logic            r_dl_vld [DL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DL; i++) begin
                r_dl_vld[i] <= 1'b0;
            end
        end else begin
            r_dl_vld[0] <= r_s2_vld;
            for (int i = 1; i < DL; i++) begin
                r_dl_vld[i] <= r_dl_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dl[0] <= r_s2_side;
        for (int i = 1; i < DL; i++) begin
            r_dl[i] <= r_dl[i-1];
        end
    end

    // rotation bottom row
    logic                   r_a_vld, r_b_vld, r_c_vld;
    logic signed [PZW-1:0]  r_a_pz, r_b_pz, r_c_pz;
    logic signed [55:0]     r_a_bx, r_a_by;
    logic signed [52:0]     r_a_ay, r_a_ax;
    logic signed [40:0]     r_b_r20, r_b_r21;
    logic [57:0]            r_c_pw;
    logic [56:0]            r_c_pt;
    logic [40:0]            w_m20, w_m21;

    always_comb begin
        w_m20 = r_b_r20[40] ? (~r_b_r20 + 1'b1) : r_b_r20;
        w_m21 = r_b_r21[40] ? (~r_b_r21 + 1'b1) : r_b_r21;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_a_vld <= r_dl_vld[DL-1];
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_pz <= r_dl[DL-1].pz;
        r_a_bx <= $signed(w_b) * $signed(r_dl[DL-1].pxz);
        r_a_by <= $signed(w_b) * $signed(r_dl[DL-1].pyz);
        r_a_ay <= $signed(w_a) * $signed(r_dl[DL-1].ry);
        r_a_ax <= $signed(w_a) * $signed(r_dl[DL-1].rx);

        r_b_pz  <= r_a_pz;
        r_b_r20 <= rnd_b17(r_a_bx) - rnd_a16(r_a_ay);
        r_b_r21 <= rnd_b17(r_a_by) + rnd_a16(r_a_ax);

        r_c_pz <= r_b_pz;
        r_c_pw <= 58'(w_m20) * 58'(gtcc_pkg::WIDTH_Q20);
        r_c_pt <= 57'(w_m21) * 57'(gtcc_pkg::THICK_Q20);
    end

    // drop, lift and clamp
    logic [58:0]                   w_dsum;
    logic [27:0]                   n_drop;
    logic signed [30:0]            n_lift;
    logic [gtcc_pkg::LIFT_W-1:0]   n_lclamp;
    logic signed [PZW-1:0]         n_adj;

    always_comb begin
        w_dsum = 59'(r_c_pw) + 59'(r_c_pt) + (59'd1 << 30);
        n_drop = 28'(w_dsum >> 31);
        n_lift = $signed({10'b0, r_thr}) - 31'(r_c_pz) + $signed({3'b0, n_drop});
        if (n_lift < 0) begin
            n_lclamp = '0;
        end else if (n_lift > $signed(31'(gtcc_pkg::LIFT_MAX))) begin
            n_lclamp = gtcc_pkg::LIFT_MAX;
        end else begin
            n_lclamp = gtcc_pkg::LIFT_W'(n_lift);
        end
        n_adj = r_c_pz + PZW'(n_lclamp);
    end

    logic                          r_o_vld;
    logic signed [PZW-1:0]         r_o_adj;
    logic [gtcc_pkg::LIFT_W-1:0]   r_o_lift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_adj  <= n_adj;
        r_o_lift <= n_lclamp;
    end

    assign o_valid       = r_o_vld;
    assign o_adjusted_z  = r_o_adj;
    assign o_lift_amount = r_o_lift;

    `GTCC_ASSERT_NEXT(a_rst_clears_strobe, !i_rst_n, !o_valid)
    `GTCC_ASSERT_DELAY(a_request_to_strobe, start && !busy, LAT, o_valid)
    `GTCC_ASSERT_IMP(a_strobe_from_request, o_valid, $past(start, LAT))

endmodule

`default_nettype wire

/* tb/gripper_table_clearance_clamp_tb.sv */
// Self-checking testbench for the gripper table clearance clamp
`timescale 1ns / 1ps

module gripper_table_clearance_clamp_tb;

    typedef struct {
        logic [gtcc_pkg::PZ_W-1:0]  pz;
        logic [gtcc_pkg::ROT_W-1:0] rx;
        logic [gtcc_pkg::ROT_W-1:0] ry;
        logic [gtcc_pkg::ROT_W-1:0] rz;
    } t_pose;

    typedef struct {
        logic [gtcc_pkg::ADJ_W-1:0]  adj;
        logic [gtcc_pkg::LIFT_W-1:0] lift;
    } t_clamp;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              start;
    logic                              busy;
    logic signed [gtcc_pkg::PZ_W-1:0]  i_position_z;
    logic signed [gtcc_pkg::ROT_W-1:0] i_rotation_x;
    logic signed [gtcc_pkg::ROT_W-1:0] i_rotation_y;
    logic signed [gtcc_pkg::ROT_W-1:0] i_rotation_z;
    logic                              o_valid;
    logic signed [gtcc_pkg::ADJ_W-1:0] o_adjusted_z;
    logic [gtcc_pkg::LIFT_W-1:0]       o_lift_amount;
    logic                              i_cfg_valid;
    logic                              o_cfg_ready;
    logic [gtcc_pkg::THR_W-1:0]        i_cfg_data;

    t_pose       pose_q[$];
    t_clamp      height_q[$];
    logic [gtcc_pkg::THR_W-1:0] thr_model;
    int          mismatches;
    bit          idle_en;

    gripper_table_clearance_clamp dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_position_z(i_position_z), .i_rotation_x(i_rotation_x),
        .i_rotation_y(i_rotation_y), .i_rotation_z(i_rotation_z),
        .o_valid(o_valid), .o_adjusted_z(o_adjusted_z), .o_lift_amount(o_lift_amount),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    function automatic longint round_div(longint x, longint y, longint unsigned d);
        longint unsigned m;
        longint unsigned q;
        m = (x < 0 ? -x : x) * (y < 0 ? -y : y);
        q = (m + d / 2) / d;
        return ((x < 0) != (y < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint trig_series(longint u, int first);
        longint h;
        longint unsigned f;
        h = longint'(1) << 30;
        for (int k = gtcc_pkg::SERIES_TERMS; k >= 1; k--) begin
            f = 2 * k + first;
            h = (longint'(1) << 30) - round_div(u, h, (f * (f + 1)) << 20);
        end
        return h;
    endfunction

    function automatic t_clamp clamp_height(t_pose p, logic [gtcc_pkg::THR_W-1:0] thr);
        longint pz, rx, ry, rz, u, sa, sb, pxz, pyz, r20, r21, drop, lift;
        t_clamp c;
        pz = longint'($signed(p.pz));
        rx = longint'($signed(p.rx));
        ry = longint'($signed(p.ry));
        rz = longint'($signed(p.rz));
        u = (rx * rx + ry * ry + rz * rz + 2048) >>> 12;
        sa = trig_series(u, 0);
        sb = trig_series(u, 1);
        pxz = round_div(rx * rz, 1, 64'd1 << 16);
        pyz = round_div(ry * rz, 1, 64'd1 << 16);
        r20 = round_div(sb, pxz, 64'd1 << 17) - round_div(sa, ry, 64'd1 << 16);
        r21 = round_div(sb, pyz, 64'd1 << 17) + round_div(sa, rx, 64'd1 << 16);
        drop = ((r20 < 0 ? -r20 : r20) * 104858 + (r21 < 0 ? -r21 : r21) * 58196
                + (longint'(1) << 30)) >>> 31;
        lift = longint'(thr) - pz + drop;
        if (lift < 0) lift = 0;
        if (lift > 4194303) lift = 4194303;
        c.adj = gtcc_pkg::ADJ_W'(pz + lift);
        c.lift = gtcc_pkg::LIFT_W'(lift);
        return c;
    endfunction

    // accept requests and register writes
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            height_q.insert(height_q.size(), clamp_height(pose_q[0], thr_model));
            pose_q.pop_front();
        end
        if (i_rst_n && i_cfg_valid && o_cfg_ready)
            thr_model <= i_cfg_data;
    end

    always @(negedge i_clk) begin
        if (i_rst_n && pose_q.size() > 0 && !(idle_en && $urandom_range(99) < 13)) begin
            start <= 1'b1;
            i_position_z <= pose_q[0].pz;
            i_rotation_x <= pose_q[0].rx;
            i_rotation_y <= pose_q[0].ry;
            i_rotation_z <= pose_q[0].rz;
        end else begin
            start <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (height_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result adj=%0d lift=%0d", o_adjusted_z, o_lift_amount);
            end else begin
                if (o_adjusted_z !== height_q[0].adj || o_lift_amount !== height_q[0].lift) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected adj=%0d lift=%0d, got adj=%0d lift=%0d",
                                 $signed(height_q[0].adj), height_q[0].lift,
                                 o_adjusted_z, o_lift_amount);
                end
                height_q.pop_front();
            end
        end
    end

    function automatic logic [gtcc_pkg::ROT_W-1:0] rand_angle();
        int s;
        s = $urandom_range(9);
        if (s < 6) return gtcc_pkg::ROT_W'($urandom_range(411774) - 205887);
        if (s < 8) return gtcc_pkg::ROT_W'($urandom_range(2000) - 1000);
        return gtcc_pkg::ROT_W'($urandom);
    endfunction

    task automatic add_pose(int pz, int rx, int ry, int rz);
        t_pose p;
        p.pz = gtcc_pkg::PZ_W'(pz);
        p.rx = gtcc_pkg::ROT_W'(rx);
        p.ry = gtcc_pkg::ROT_W'(ry);
        p.rz = gtcc_pkg::ROT_W'(rz);
        pose_q.insert(pose_q.size(), p);
    endtask

    task automatic write_threshold(logic [gtcc_pkg::THR_W-1:0] v);
        while (pose_q.size() > 0 || height_q.size() > 0) @(posedge i_clk);
        repeat (90) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [gtcc_pkg::THR_W-1:0] thr_set[6];
        thr_set = '{gtcc_pkg::THRESH_RESET, 21'd0, 21'd1048576, 21'h1FFFFF, 21'd20000,
                    21'h0AAAAA};
        i_rst_n = 1'b0;
        start = 1'b0;
        i_position_z = '0;
        i_rotation_x = '0;
        i_rotation_y = '0;
        i_rotation_z = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        thr_model = gtcc_pkg::THRESH_RESET;
        mismatches = 0;
        idle_en = 1'b1;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) write_threshold(thr_set[ph]);
            idle_en = (ph != 2);
            add_pose(0, 0, 0, 0);
            add_pose(2097152, 0, 0, 0);
            add_pose(-2097152, 0, 0, 0);
            add_pose(-4194304, 262143, -262144, 262143);
            add_pose(4194303, -262144, 262143, -262144);
            add_pose(-2097152, 205887, 205887, 205887);
            add_pose(100000, -205887, 0, 205887);
            add_pose(0, 0, 205887, 0);
            add_pose(-1000, 1, -1, 1);
            add_pose(5243, 0, 0, 0);
            for (int n = 0; n < 115; n++) begin
                if ($urandom_range(9) == 0)
                    add_pose(int'($urandom) >>> 9, rand_angle(), rand_angle(), rand_angle());
                else
                    add_pose(int'($urandom_range(4194304)) - 2097152,
                             rand_angle(), rand_angle(), rand_angle());
            end
            while (pose_q.size() > 0) @(posedge i_clk);
        end
        while (height_q.size() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
